>>> src/psbs_pkg.sv
// Shared constants, codes and types of the prefix-sum bucket search block.
package psbs_pkg;

  // Table depth and prefix-sum width.
  localparam int MAX_BUCKETS = 1024;
  localparam int SUM_BITS    = 24;

  // Fixed field widths of the item channels.
  localparam int VALUE_W   = 24;
  localparam int ACTION_W  = 2;
  localparam int OUT_IDX_W = 11;

  // Derived widths: table address, bucket count and the common compare width.
  localparam int ADDR_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int CNT_W  = $clog2(MAX_BUCKETS + 1);
  localparam int CMP_W  = (SUM_BITS > VALUE_W) ? SUM_BITS : VALUE_W;

  // Action codes carried by an input item.
  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_QUERY  = 2'd2
  } action_t;

  // Access request from the controller to the prefix table.
  typedef struct packed {
    logic                we;
    logic [ADDR_W-1:0]   waddr;
    logic [SUM_BITS-1:0] wdata;
    logic                re;
    logic [ADDR_W-1:0]   raddr;
  } tbl_req_t;

endpackage

>>> src/psbs_table.sv
// Prefix-sum table: one write port and one read port with registered read data.
module psbs_table (
  input  logic                          clk,
  input  psbs_pkg::tbl_req_t            req,
  output logic [psbs_pkg::SUM_BITS-1:0] rdata
);

  logic [psbs_pkg::SUM_BITS-1:0] mem [psbs_pkg::MAX_BUCKETS];
  logic [psbs_pkg::SUM_BITS-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Read port, data registered and valid in the cycle after the request.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/psbs_ctrl.sv
// Controller: running total, appends, binary search sequencer and result register.
module psbs_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [psbs_pkg::ACTION_W-1:0]   in_action,
  input  logic [psbs_pkg::VALUE_W-1:0]    in_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [psbs_pkg::OUT_IDX_W-1:0]  out_index,
  output logic                            out_oor,
  output psbs_pkg::tbl_req_t              req,
  input  logic [psbs_pkg::SUM_BITS-1:0]   rdata
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } state_t;

  localparam logic [psbs_pkg::CMP_W:0] SUM_MAX =
    (psbs_pkg::CMP_W + 1)'({psbs_pkg::SUM_BITS{1'b1}});

  state_t                          state_r, state_nxt;
  logic [psbs_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic [psbs_pkg::SUM_BITS-1:0]   total_r, total_nxt;
  logic [psbs_pkg::CMP_W-1:0]      label_r, label_nxt;
  logic [psbs_pkg::CNT_W-1:0]      lo_r, lo_nxt;
  logic [psbs_pkg::CNT_W-1:0]      hi_r, hi_nxt;
  logic [psbs_pkg::CNT_W-1:0]      mid_r, mid_nxt;
  logic [psbs_pkg::OUT_IDX_W-1:0]  res_idx_r, res_idx_nxt;
  logic                            res_oor_r, res_oor_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [psbs_pkg::OUT_IDX_W-1:0]  out_index_r, out_index_nxt;
  logic                            out_oor_r, out_oor_nxt;

  logic                            accept;
  logic [psbs_pkg::CMP_W-1:0]      value_ext;
  logic [psbs_pkg::CMP_W:0]        sum_raw;
  logic [psbs_pkg::SUM_BITS-1:0]   sum_sat;
  logic                            table_full;
  logic                            label_oor;
  logic                            less;
  logic [psbs_pkg::CNT_W-1:0]      step_lo;
  logic [psbs_pkg::CNT_W-1:0]      step_hi;
  logic [psbs_pkg::CNT_W-1:0]      step_mid;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Saturating append sum and range check of a label.
  assign value_ext  = psbs_pkg::CMP_W'(in_value);
  assign sum_raw    = (psbs_pkg::CMP_W + 1)'(total_r) + (psbs_pkg::CMP_W + 1)'(value_ext);
  assign sum_sat    = (sum_raw > SUM_MAX) ? {psbs_pkg::SUM_BITS{1'b1}}
                                          : psbs_pkg::SUM_BITS'(sum_raw);
  assign table_full = (count_r >= psbs_pkg::CNT_W'(psbs_pkg::MAX_BUCKETS));
  assign label_oor  = (value_ext == '0) || (value_ext > psbs_pkg::CMP_W'(total_r));

  // One lower-bound step on the entry read for mid_r.
  assign less     = (psbs_pkg::CMP_W'(rdata) < label_r);
  assign step_lo  = less ? (mid_r + psbs_pkg::CNT_W'(1)) : lo_r;
  assign step_hi  = less ? hi_r : mid_r;
  assign step_mid = step_lo + ((step_hi - step_lo) >> 1);

  // Next-state logic and table requests.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    total_nxt     = total_r;
    label_nxt     = label_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    res_idx_nxt   = res_idx_r;
    res_oor_nxt   = res_oor_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_index_nxt = out_index_r;
    out_oor_nxt   = out_oor_r;
    req.we        = 1'b0;
    req.waddr     = count_r[psbs_pkg::ADDR_W-1:0];
    req.wdata     = sum_sat;
    req.re        = 1'b0;
    req.raddr     = mid_r[psbs_pkg::ADDR_W-1:0];

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_action)
            psbs_pkg::ACT_CLEAR: begin
              count_nxt = '0;
              total_nxt = '0;
            end
            psbs_pkg::ACT_APPEND: begin
              if (!table_full) begin
                req.we    = 1'b1;
                total_nxt = sum_sat;
                count_nxt = count_r + psbs_pkg::CNT_W'(1);
              end
            end
            psbs_pkg::ACT_QUERY: begin
              label_nxt = value_ext;
              if (label_oor) begin
                res_idx_nxt = '0;
                res_oor_nxt = 1'b1;
                state_nxt   = ST_DONE;
              end else begin
                // A nonzero total implies at least one bucket in the table.
                lo_nxt    = '0;
                hi_nxt    = count_r;
                mid_nxt   = count_r >> 1;
                req.re    = 1'b1;
                req.raddr = mid_nxt[psbs_pkg::ADDR_W-1:0];
                state_nxt = ST_SEARCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SEARCH: begin
        lo_nxt = step_lo;
        hi_nxt = step_hi;
        if (step_lo < step_hi) begin
          mid_nxt   = step_mid;
          req.re    = 1'b1;
          req.raddr = step_mid[psbs_pkg::ADDR_W-1:0];
        end else begin
          res_idx_nxt = psbs_pkg::OUT_IDX_W'({1'b0, step_lo} + (psbs_pkg::CNT_W + 1)'(1));
          res_oor_nxt = 1'b0;
          state_nxt   = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hand the result over once the output register is free.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = res_idx_r;
          out_oor_nxt   = res_oor_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State, counters and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
    label_r     <= label_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    res_idx_r   <= res_idx_nxt;
    res_oor_r   <= res_oor_nxt;
    out_index_r <= out_index_nxt;
    out_oor_r   <= out_oor_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_index = out_index_r;
  assign out_oor   = out_oor_r;

endmodule

>>> src/prefix_sum_bucket_search.sv
// Top level of the prefix-sum bucket search block.
//
// Append items write the saturated running total into the next entry of a
// 1024-entry prefix table held in one synchronous memory, and clear items
// reset the count and total; both give no result. A query item that is in
// range runs a lower-bound binary search, one step per cycle on the table's
// single read port, and then moves its result to the output register, where
// it is offered once that register is free; an out-of-range query skips the
// search. Only one item is at work at a time, and appends are accepted while
// a result still waits to be taken. The table is not cleared after reset;
// only entries below the bucket count are ever read.
module prefix_sum_bucket_search (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [23:0] value
  input  logic [1:0]  in_tuser,   // [1:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [10:0] bucket_index, [15:11] zero
  output logic [0:0]  out_tuser   // [0] out_of_range
);

  psbs_pkg::tbl_req_t                    req;
  logic [psbs_pkg::SUM_BITS-1:0]         rdata;
  logic [psbs_pkg::OUT_IDX_W-1:0]        out_index;
  logic                                  out_oor;

  psbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_action (in_tuser),
    .in_value  (in_tdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_index (out_index),
    .out_oor   (out_oor),
    .req       (req),
    .rdata     (rdata)
  );

  psbs_table u_table (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  assign out_tdata = 16'(out_index);
  assign out_tuser = out_oor;

endmodule
